@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the matrix multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked while rst is high.
`define SMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst is high.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/smm_pkg.sv @@
// Shared constants and controller/datapath interface types for the matrix multiplier.
package smm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W      = 16;
  localparam int RES_W       = 32;
  localparam int CFG_W       = 2;

  localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // store the loaded pair at (row, col)
    logic rd_en;     // read A[row][col] and row col of B
    logic first_k;   // first term of a dot product
    logic last_k;    // last term of a dot product
    logic last_row;  // row being read is the final row of C
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic busy;      // a row is in the pipeline or waits in the accumulators
  } sts_t;

endpackage

@@ rtl/smm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/smm_ctrl.sv @@
// Controller: size register, load/compute sequencing and row/column counters.
module smm_ctrl #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int CNT_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [smm_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  output smm_pkg::cmd_t            cmd,
  input  smm_pkg::sts_t            sts,
  output logic [IDX_W-1:0]         row_idx,
  output logic [IDX_W-1:0]         col_idx,
  output logic [CNT_W-1:0]         dim
);

  import smm_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_WAIT
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   size_log2;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [3:0]         pow;
  logic [IDX_W-1:0]   dim_m1;

  // Active dimension, saturated to MAX_DIM
  always_comb begin
    pow    = 4'd1 << size_log2;
    dim    = (pow > 4'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(pow);
    dim_m1 = IDX_W'(dim - CNT_W'(1));
  end

  // Row/col serve as load position during loading and as (i, k) while computing
  assign row_idx  = row;
  assign col_idx  = col;
  assign in_stall = (state != S_LOAD);

  always_comb begin
    cmd.wr_en    = in_valid && (state == S_LOAD);
    cmd.rd_en    = (state == S_ISSUE);
    cmd.first_k  = (col == '0);
    cmd.last_k   = (col == dim_m1);
    cmd.last_row = (row == dim_m1);
  end

  // State machine and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      size_log2 <= SIZE_LOG2_RST;
      row       <= '0;
      col       <= '0;
    end else if (cfg_wr_en) begin
      // size change drops any partial load
      size_log2 <= cfg_wr_data;
      row       <= '0;
      col       <= '0;
      state     <= S_LOAD;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (col == dim_m1) begin
              col <= '0;
              if (row == dim_m1) begin
                row   <= '0;
                state <= S_ISSUE;
              end else begin
                row <= IDX_W'(row + 1'b1);
              end
            end else begin
              col <= IDX_W'(col + 1'b1);
            end
          end
        end
        S_ISSUE: begin
          if (col == dim_m1) begin
            col   <= '0;
            state <= S_WAIT;
          end else begin
            col <= IDX_W'(col + 1'b1);
          end
        end
        S_WAIT: begin
          // next row starts once the accumulators are handed to the output buffer
          if (!sts.busy) begin
            if (row == dim_m1) begin
              row   <= '0;
              state <= S_LOAD;
            end else begin
              row   <= IDX_W'(row + 1'b1);
              state <= S_ISSUE;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

@@ rtl/smm_datapath.sv @@
// Datapath: operand stores, one multiplier per column lane, accumulators, output row buffer.
module smm_datapath #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  parameter int CNT_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  smm_pkg::cmd_t                   cmd,
  output smm_pkg::sts_t                   sts,
  input  logic [IDX_W-1:0]                row_idx,
  input  logic [IDX_W-1:0]                col_idx,
  input  logic [CNT_W-1:0]                dim,
  input  logic signed [smm_pkg::ELEM_W-1:0] a_elem,
  input  logic signed [smm_pkg::ELEM_W-1:0] b_elem,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [smm_pkg::RES_W-1:0]  c_elem,
  output logic                            last
);

  import smm_pkg::*;

  localparam int A_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;

  logic [AAW-1:0]           a_addr;
  logic signed [ELEM_W-1:0] a_q;
  logic signed [ELEM_W-1:0] b_q  [MAX_DIM];
  logic signed [RES_W-1:0]  prod [MAX_DIM];
  logic [RES_W-1:0]         acc  [MAX_DIM];
  logic [RES_W-1:0]         obuf [MAX_DIM];

  logic             v1, first1, last1, lrow1;
  logic             v2, first2, last2, lrow2;
  logic             acc_full, acc_lrow;
  logic [CNT_W-1:0] ocnt;
  logic             olrow;
  logic             xfer;
  logic             out_fire;

  // A is stored row-major at a fixed MAX_DIM stride
  assign a_addr = AAW'(AAW'(row_idx) * AAW'(MAX_DIM) + AAW'(col_idx));

  smm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (A_DEPTH)
  ) u_a_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (a_addr),
    .wdata (a_elem),
    .raddr (a_addr),
    .rdata (a_q)
  );

  // B is banked by column: bank j holds column j, addressed by row
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_bank
    smm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_DIM)
    ) u_b_ram (
      .clk   (clk),
      .we    (cmd.wr_en && (col_idx == IDX_W'(j))),
      .waddr (row_idx),
      .wdata (b_elem),
      .raddr (col_idx),
      .rdata (b_q[j])
    );
  end

  assign xfer     = acc_full && (ocnt == '0);
  assign out_fire = out_valid && !out_stall;

  // Pipeline valids, accumulator and output buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      acc_full <= 1'b0;
      ocnt     <= '0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      if (v2 && last2) begin
        acc_full <= 1'b1;
      end else if (xfer) begin
        acc_full <= 1'b0;
      end
      if (xfer) begin
        ocnt <= dim;
      end else if (out_fire) begin
        ocnt <= CNT_W'(ocnt - CNT_W'(1));
      end
    end
  end

  // Tags travel alongside the operands
  always_ff @(posedge clk) begin
    first1 <= cmd.first_k;
    last1  <= cmd.last_k;
    lrow1  <= cmd.last_row;
    first2 <= first1;
    last2  <= last1;
    lrow2  <= lrow1;
    if (v2 && last2) begin
      acc_lrow <= lrow2;
    end
    if (xfer) begin
      olrow <= acc_lrow;
    end
  end

  // Multiply and accumulate, one lane per column of C
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_DIM; j++) begin
      prod[j] <= RES_W'(a_q) * RES_W'(b_q[j]);
      if (v2) begin
        acc[j] <= first2 ? prod[j] : RES_W'(acc[j] + prod[j]);
      end
    end
  end

  // Output row buffer: loaded whole, shifted out one element per transaction
  always_ff @(posedge clk) begin
    if (xfer) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        obuf[j] <= acc[j];
      end
    end else if (out_fire) begin
      for (int j = 0; j < MAX_DIM - 1; j++) begin
        obuf[j] <= obuf[j+1];
      end
    end
  end

  assign sts.busy  = v1 || v2 || acc_full;
  assign out_valid = (ocnt != '0);
  assign c_elem    = $signed(obuf[0]);
  assign last      = olrow && (ocnt == CNT_W'(1));

endmodule

@@ rtl/square_matrix_multiply.sv @@
// Top level of the square matrix multiplier: controller plus datapath.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_wr_en             cfg_wr_data (size_log2)
//   in        in         in_valid / in_stall   a_elem, b_elem
//   out       out        out_valid / out_stall c_elem, last
//
// Loading takes the n*n pairs of an n x n matrix, one pair per handshake while in_stall is low.
// Each row of C then takes n store reads, one A element per read, followed by the multiply,
// the accumulate and the hand-off to the output buffer; the single A read port sets this pace.
// A row drains from the output buffer while the next row is being computed.
// rst is synchronous and clears control state only; the stores are not cleared.
// in_stall is high from the last loaded pair until the last row reaches the output buffer.
module square_matrix_multiply #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [smm_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [smm_pkg::ELEM_W-1:0] a_elem,
  input  logic signed [smm_pkg::ELEM_W-1:0] b_elem,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [smm_pkg::RES_W-1:0]  c_elem,
  output logic                              last
);

  import smm_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic [CNT_W-1:0] dim;

  smm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .sts         (sts),
    .row_idx     (row_idx),
    .col_idx     (col_idx),
    .dim         (dim)
  );

  smm_datapath #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .row_idx   (row_idx),
    .col_idx   (col_idx),
    .dim       (dim),
    .a_elem    (a_elem),
    .b_elem    (b_elem),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .c_elem    (c_elem),
    .last      (last)
  );

endmodule

@@ rtl/smm_checker.sv @@
// Port-level checker for the matrix multiplier and its bind to the top level.
`include "assert_macros.svh"

module smm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [smm_pkg::RES_W-1:0]  c_elem,
  input logic                              last
);

  // A stalled result transaction holds its payload
  `SMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(c_elem) && $stable(last), "stalled result changed")

  // last only marks a valid result
  `SMM_ASSERT_SAME(a_last_valid, last, out_valid, "last without out_valid")

  // Nothing follows the final element until a new matrix is loaded
  `SMM_ASSERT_NEXT(a_gap_after_last, out_valid && !out_stall && last,
                   !out_valid, "result right after final element")

  // A row reaches the output only while the input side is held off
  `SMM_ASSERT_SAME(a_row_during_compute, $rose(out_valid), in_stall,
                   "row appeared while loading")

endmodule

bind square_matrix_multiply smm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .c_elem    (c_elem),
  .last      (last)
);
